// ===== hdl/lz4_pkg.sv =====
// ---------------------------------------------------------------------------
// lz4_pkg
// types and constants shared by the lz4 block decompressor modules
// ---------------------------------------------------------------------------
package lz4_pkg;

    localparam int WINDOW_BYTES_DEF = 65536;
    localparam int LENGTH_BITS_DEF  = 32;

    localparam logic [7:0] MAGIC0 = 8'h04;
    localparam logic [7:0] MAGIC1 = 8'h22;
    localparam logic [7:0] MAGIC2 = 8'h4D;
    localparam logic [7:0] MAGIC3 = 8'h18;
    localparam logic [7:0] EXT_CONT = 8'hFF;
    localparam logic [3:0] NIB_EXT  = 4'hF;
    localparam logic [3:0] DESC_LEN_SHORT = 4'd3;
    localparam logic [3:0] DESC_LEN_LONG  = 4'd11;
    localparam int         MIN_MATCH = 4;
    localparam int         CS_FLAG_BIT = 3;

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'd0,
        PH_DESC   = 4'd1,
        PH_BSIZE  = 4'd2,
        PH_TOKEN  = 4'd3,
        PH_LITEXT = 4'd4,
        PH_LIT    = 4'd5,
        PH_OFF0   = 4'd6,
        PH_OFF1   = 4'd7,
        PH_MEXT   = 4'd8,
        PH_MATCH  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_OFF = 3'd1,
        ST_BAD_MAG = 3'd2,
        ST_BUSY    = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        status_t    status;
        logic       match_pending;
        logic       block_done;
    } result_t;

endpackage

// ===== hdl/lz4_block_decompressor_top.sv =====
// ---------------------------------------------------------------------------
// lz4_block_decompressor_top
// lz4 block decoder with 64 KiB history and stream ports
// ---------------------------------------------------------------------------
// Each request either parses a compressed byte or, as a pull, reads one
// match byte from the history ram, whose address for the next pull is set up
// in the same cycle so pulls run back to back; a byte written in the previous
// cycle is forwarded around the ram. Every request gives exactly one result,
// held in an output register; a new request is taken whenever that register is
// empty or being drained. Writing frame_mode restarts the decoder.
module lz4_block_decompressor_top #(
    parameter int WINDOW_BYTES = lz4_pkg::WINDOW_BYTES_DEF,
    parameter int LENGTH_BITS  = lz4_pkg::LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // command
    input  logic        s_tlast,   // end_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte, byte_valid, status, match_pending, pad
    output logic        m_tlast    // block_done
);
    localparam int AW = $clog2(WINDOW_BYTES);

    lz4_pkg::result_t res, res_reg;
    logic             step, vld_reg;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [7:0]       wdata, rdata;

    assign s_tready = !vld_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    lz4_decoder #(.WINDOW_BYTES(WINDOW_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_dec (
        .aclk, .aresetn, .cfg_we, .cfg_mode(cfg_wdata), .step,
        .cmd(s_tuser), .din(s_tdata), .eob(s_tlast),
        .res,
        .mem_we(we), .mem_waddr(waddr), .mem_wdata(wdata),
        .mem_re(re), .mem_raddr(raddr), .mem_rdata(rdata)
    );

    lz4_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .aclk, .we, .waddr, .wdata, .re, .raddr, .rdata
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (step) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {3'd0, res_reg.match_pending, res_reg.status,
                       res_reg.byte_valid, res_reg.out_byte};
    assign m_tlast  = res_reg.block_done;
endmodule

// ===== hdl/lz4_ram.sv =====
// ---------------------------------------------------------------------------
// lz4_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
module lz4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/lz4_decoder.sv =====
// ---------------------------------------------------------------------------
// lz4_decoder
// sequence parser: header, token, lengths, literals, offset, match control
// ---------------------------------------------------------------------------
module lz4_decoder #(
    parameter int WINDOW_BYTES = lz4_pkg::WINDOW_BYTES_DEF,
    parameter int LENGTH_BITS  = lz4_pkg::LENGTH_BITS_DEF,
    localparam int AW = $clog2(WINDOW_BYTES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_mode,
    input  logic                step,
    input  logic                cmd,
    input  logic [7:0]          din,
    input  logic                eob,
    output lz4_pkg::result_t    res,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [7:0]          mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [7:0]          mem_rdata
);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [AW:0] WIN = (AW+1)'(WINDOW_BYTES);

    lz4_pkg::phase_t        phase_reg, phase_next;
    logic                   mode_reg;
    logic [3:0]             hcnt_reg, hcnt_next;
    logic                   csf_reg, csf_next;
    logic [31:0]            bsize_reg, bsize_next;
    logic [31:0]            cons_reg, cons_next;
    logic [3:0]             mnib_reg, mnib_next;
    logic [LENGTH_BITS-1:0] lit_reg, lit_next;
    logic [LENGTH_BITS-1:0] mlen_reg, mlen_next;
    logic [15:0]            off_reg, off_next;
    logic [AW:0]            prod_reg, prod_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [7:0]             lastw_reg;
    logic                   lastw_vld_reg;

    lz4_pkg::status_t       st;
    logic                   done, emit;
    logic [7:0]             obyte;
    logic [LENGTH_BITS:0]   sum_l, sum_m, sum_m4;
    logic [LENGTH_BITS-1:0] mlen_ext;
    logic [7:0]             mbyte;
    logic [3:0]             desc_len;

    function automatic logic [7:0] magic_at(input logic [1:0] i);
        case (i)
            2'd0:    magic_at = lz4_pkg::MAGIC0;
            2'd1:    magic_at = lz4_pkg::MAGIC1;
            2'd2:    magic_at = lz4_pkg::MAGIC2;
            default: magic_at = lz4_pkg::MAGIC3;
        endcase
    endfunction

    function automatic logic bad_off(input logic [15:0] o, input logic [AW:0] p);
        bad_off = (o == 16'd0) || ({1'b0, o} > 17'(p));
    endfunction

    // the match read address is the next write pointer minus the offset; the byte
    // written last cycle may not be visible yet, so forward it
    assign mem_raddr = AW'(wp_next - AW'(off_next));
    assign mem_re    = 1'b1;

    always_comb begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        csf_next   = csf_reg;
        bsize_next = bsize_reg;
        cons_next  = cons_reg;
        mnib_next  = mnib_reg;
        lit_next   = lit_reg;
        mlen_next  = mlen_reg;
        off_next   = off_reg;
        prod_next  = prod_reg;
        wp_next    = wp_reg;
        st         = lz4_pkg::ST_OK;
        done       = 1'b0;
        emit       = 1'b0;
        obyte      = din;
        desc_len   = lz4_pkg::DESC_LEN_SHORT;
        sum_l      = {1'b0, lit_reg} + (LENGTH_BITS+1)'(din);
        sum_m      = {1'b0, mlen_reg} + (LENGTH_BITS+1)'(din);
        mlen_ext   = sum_m[LENGTH_BITS] ? LEN_MAX : sum_m[LENGTH_BITS-1:0];
        sum_m4     = {1'b0, mlen_ext} + (LENGTH_BITS+1)'(lz4_pkg::MIN_MATCH);
        mbyte      = lastw_vld_reg ? lastw_reg : mem_rdata;
        if (step) begin
            if (cmd) begin
                if (phase_reg == lz4_pkg::PH_MATCH) begin
                    emit     = 1'b1;
                    obyte    = mbyte;
                    mlen_next = mlen_reg - 1'b1;
                    if (mlen_reg == LENGTH_BITS'(1)) begin
                        phase_next = lz4_pkg::PH_TOKEN;
                    end
                end else begin
                    st = lz4_pkg::ST_NONE;
                end
            end else if (phase_reg == lz4_pkg::PH_MATCH) begin
                st = lz4_pkg::ST_BUSY;
            end else if (phase_reg == lz4_pkg::PH_MAGIC) begin
                if (din != magic_at(hcnt_reg[1:0])) begin
                    st   = lz4_pkg::ST_BAD_MAG;
                    done = 1'b1;
                end else if (hcnt_reg >= 4'd3) begin
                    phase_next = lz4_pkg::PH_DESC;
                    hcnt_next  = '0;
                end else begin
                    hcnt_next = hcnt_reg + 1'b1;
                end
            end else if (phase_reg == lz4_pkg::PH_DESC) begin
                if (hcnt_reg == 4'd0) begin
                    csf_next = din[lz4_pkg::CS_FLAG_BIT];
                end
                desc_len  = csf_next ? lz4_pkg::DESC_LEN_LONG : lz4_pkg::DESC_LEN_SHORT;
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_next >= desc_len) begin
                    phase_next = lz4_pkg::PH_BSIZE;
                    hcnt_next  = '0;
                    bsize_next = '0;
                end
            end else if (phase_reg == lz4_pkg::PH_BSIZE) begin
                case (hcnt_reg[1:0])
                    2'd0:    bsize_next[7:0]   = din;
                    2'd1:    bsize_next[15:8]  = din;
                    2'd2:    bsize_next[23:16] = din;
                    default: bsize_next[31:24] = din;
                endcase
                hcnt_next = hcnt_reg + 1'b1;
                if (hcnt_next >= 4'd4) begin
                    phase_next = lz4_pkg::PH_TOKEN;
                    hcnt_next  = '0;
                    cons_next  = '0;
                    if (bsize_next == 32'd0) begin
                        done = 1'b1;
                    end
                end
            end else begin
                case (phase_reg)
                    lz4_pkg::PH_TOKEN: begin
                        mnib_next = din[3:0];
                        lit_next  = LENGTH_BITS'(din[7:4]);
                        if (din[7:4] == lz4_pkg::NIB_EXT) begin
                            phase_next = lz4_pkg::PH_LITEXT;
                        end else if (din[7:4] != 4'd0) begin
                            phase_next = lz4_pkg::PH_LIT;
                        end else begin
                            phase_next = lz4_pkg::PH_OFF0;
                        end
                    end
                    lz4_pkg::PH_LITEXT: begin
                        lit_next = sum_l[LENGTH_BITS] ? LEN_MAX : sum_l[LENGTH_BITS-1:0];
                        if (din != lz4_pkg::EXT_CONT) begin
                            phase_next = lz4_pkg::PH_LIT;
                        end
                    end
                    lz4_pkg::PH_LIT: begin
                        emit     = 1'b1;
                        lit_next = lit_reg - 1'b1;
                        if (lit_reg == LENGTH_BITS'(1)) begin
                            phase_next = lz4_pkg::PH_OFF0;
                        end
                    end
                    lz4_pkg::PH_OFF0: begin
                        off_next   = {8'd0, din};
                        phase_next = lz4_pkg::PH_OFF1;
                    end
                    lz4_pkg::PH_OFF1: begin
                        off_next = {din, off_reg[7:0]};
                        if (mnib_reg == lz4_pkg::NIB_EXT) begin
                            mlen_next  = LENGTH_BITS'(15);
                            phase_next = lz4_pkg::PH_MEXT;
                        end else begin
                            mlen_next = LENGTH_BITS'(mnib_reg) + LENGTH_BITS'(lz4_pkg::MIN_MATCH);
                            if (bad_off(off_next, prod_reg)) begin
                                st = lz4_pkg::ST_BAD_OFF;
                            end else begin
                                phase_next = lz4_pkg::PH_MATCH;
                            end
                        end
                    end
                    default: begin
                        mlen_next = mlen_ext;
                        if (din != lz4_pkg::EXT_CONT) begin
                            mlen_next = sum_m4[LENGTH_BITS] ? LEN_MAX
                                                            : sum_m4[LENGTH_BITS-1:0];
                            if (bad_off(off_reg, prod_reg)) begin
                                st = lz4_pkg::ST_BAD_OFF;
                            end else begin
                                phase_next = lz4_pkg::PH_MATCH;
                            end
                        end
                    end
                endcase
                cons_next = cons_reg + 1'b1;
                if (st != lz4_pkg::ST_OK) begin
                    done = 1'b1;
                end else if (mode_reg ? (cons_next >= bsize_reg) : eob) begin
                    done = 1'b1;
                end
            end
            if (emit) begin
                wp_next = wp_reg + 1'b1;
                if (prod_reg < WIN) begin
                    prod_next = prod_reg + 1'b1;
                end
            end
            if (done) begin
                phase_next = mode_reg ? lz4_pkg::PH_MAGIC : lz4_pkg::PH_TOKEN;
                hcnt_next  = '0;
                csf_next   = 1'b0;
                bsize_next = '0;
                cons_next  = '0;
                mnib_next  = '0;
                lit_next   = '0;
                mlen_next  = '0;
                off_next   = '0;
                prod_next  = '0;
                wp_next    = '0;
            end
        end
    end

    assign mem_we    = step && emit;
    assign mem_waddr = wp_reg;
    assign mem_wdata = obyte;

    assign res.out_byte      = emit ? obyte : 8'd0;
    assign res.byte_valid    = emit;
    assign res.status        = st;
    assign res.match_pending = (phase_next == lz4_pkg::PH_MATCH);
    assign res.block_done    = done;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            mode_reg  <= aresetn ? cfg_mode : 1'b0;
            phase_reg <= (aresetn && cfg_mode) ? lz4_pkg::PH_MAGIC : lz4_pkg::PH_TOKEN;
            hcnt_reg  <= '0;
            csf_reg   <= 1'b0;
            bsize_reg <= '0;
            cons_reg  <= '0;
            mnib_reg  <= '0;
            lit_reg   <= '0;
            mlen_reg  <= '0;
            off_reg   <= '0;
            prod_reg  <= '0;
            wp_reg    <= '0;
            lastw_vld_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            csf_reg   <= csf_next;
            bsize_reg <= bsize_next;
            cons_reg  <= cons_next;
            mnib_reg  <= mnib_next;
            lit_reg   <= lit_next;
            mlen_reg  <= mlen_next;
            off_reg   <= off_next;
            prod_reg  <= prod_next;
            wp_reg    <= wp_next;
            // next read address equals this write address when offset is one
            lastw_vld_reg <= mem_we && (mem_raddr == wp_reg);
        end
        lastw_reg <= obyte;
    end
endmodule

// ===== hdl/lz4_checker.sv =====
// ---------------------------------------------------------------------------
// lz4_checker
// port-level checks for the lz4 block decompressor
// ---------------------------------------------------------------------------
module lz4_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("request gave no result");
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("byte without valid flag");
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[11:9] == 3'd1 || m_tdata[11:9] == 3'd2) |-> m_tlast
            && !m_tdata[12])
        else $error("error without block end");
endmodule

bind lz4_block_decompressor_top lz4_checker u_chk (.*);

// ===== verif/tb_lz4_block_decompressor_top.sv =====
// ---------------------------------------------------------------------------
// tb_lz4_block_decompressor_top
// stream testbench: directed raw table and frame checks, then random lz4
// sequences and frames, every result compared with an in-bench decoder model
// ---------------------------------------------------------------------------
module tb_lz4_block_decompressor_top;

    typedef struct packed {
        logic       pull;
        logic [7:0] data;
        logic       eob;
    } req_t;

    typedef struct {
        req_t             rq;
        logic             chk;
        lz4_pkg::result_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    lz4_block_decompressor_top DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // decoder model state
    logic             mdl_frame;
    lz4_pkg::phase_t  mdl_ph;
    logic [3:0]       mdl_hcnt;
    logic             mdl_csflag;
    logic [31:0]      mdl_bsize, mdl_consumed, mdl_lit_left, mdl_mat_left;
    logic [3:0]       mdl_mnib;
    logic [15:0]      mdl_offset, mdl_wptr;
    logic [16:0]      mdl_produced;
    logic [7:0]       mdl_hist [0:65535];

    lz4_pkg::result_t expected_q[$];
    int       errors = 0;
    int       idle_send = 0, idle_recv = 0;
    int       random_items = 0;

    task automatic report(input string msg);
        $display("mismatch: %s at %0t", msg, $time);
        errors++;
    endtask

    function automatic void mdl_restart();
        mdl_ph = mdl_frame ? lz4_pkg::PH_MAGIC : lz4_pkg::PH_TOKEN;
        mdl_hcnt = '0; mdl_csflag = 1'b0; mdl_bsize = '0; mdl_consumed = '0;
        mdl_mnib = '0; mdl_lit_left = '0; mdl_mat_left = '0; mdl_offset = '0;
        mdl_produced = '0; mdl_wptr = '0;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void mdl_emit(input logic [7:0] b);
        mdl_hist[mdl_wptr] = b;
        mdl_wptr++;
        if (mdl_produced < 17'd65536) mdl_produced++;
    endfunction

    function automatic lz4_pkg::status_t mdl_start_match();
        if (mdl_offset == 0 || {1'b0, mdl_offset} > mdl_produced) return lz4_pkg::ST_BAD_OFF;
        mdl_ph = lz4_pkg::PH_MATCH;
        return lz4_pkg::ST_OK;
    endfunction

    function automatic lz4_pkg::result_t decode_step(input req_t rq);
        lz4_pkg::result_t r;
        logic [7:0] v, b;
        logic done;
        logic [7:0] magic [4];
        magic = '{lz4_pkg::MAGIC0, lz4_pkg::MAGIC1, lz4_pkg::MAGIC2, lz4_pkg::MAGIC3};
        r = '0;
        r.status = lz4_pkg::ST_OK;
        done = 1'b0;
        b = rq.data;
        if (rq.pull) begin
            if (mdl_ph == lz4_pkg::PH_MATCH) begin
                v = mdl_hist[mdl_wptr - mdl_offset];
                mdl_emit(v);
                r.out_byte = v; r.byte_valid = 1'b1;
                mdl_mat_left--;
                if (mdl_mat_left == 0) mdl_ph = lz4_pkg::PH_TOKEN;
            end else r.status = lz4_pkg::ST_NONE;
        end else if (mdl_ph == lz4_pkg::PH_MATCH) begin
            r.status = lz4_pkg::ST_BUSY;
        end else if (mdl_ph == lz4_pkg::PH_MAGIC) begin
            if (b != magic[mdl_hcnt[1:0]]) begin
                r.status = lz4_pkg::ST_BAD_MAG; done = 1'b1;
            end else if (mdl_hcnt >= 3) begin
                mdl_ph = lz4_pkg::PH_DESC; mdl_hcnt = '0;
            end else mdl_hcnt++;
        end else if (mdl_ph == lz4_pkg::PH_DESC) begin
            if (mdl_hcnt == 0) mdl_csflag = b[lz4_pkg::CS_FLAG_BIT];
            mdl_hcnt++;
            if (mdl_hcnt >= (mdl_csflag ? lz4_pkg::DESC_LEN_LONG
                                        : lz4_pkg::DESC_LEN_SHORT)) begin
                mdl_ph = lz4_pkg::PH_BSIZE; mdl_hcnt = '0; mdl_bsize = '0;
            end
        end else if (mdl_ph == lz4_pkg::PH_BSIZE) begin
            mdl_bsize |= 32'(b) << (8 * mdl_hcnt[1:0]);
            mdl_hcnt++;
            if (mdl_hcnt >= 4) begin
                mdl_ph = lz4_pkg::PH_TOKEN; mdl_hcnt = '0; mdl_consumed = '0;
                if (mdl_bsize == 0) done = 1'b1;
            end
        end else begin
            case (mdl_ph)
                lz4_pkg::PH_TOKEN: begin
                    mdl_mnib = b[3:0];
                    mdl_lit_left = 32'(b[7:4]);
                    if (b[7:4] == lz4_pkg::NIB_EXT) mdl_ph = lz4_pkg::PH_LITEXT;
                    else if (b[7:4] != 0) mdl_ph = lz4_pkg::PH_LIT;
                    else mdl_ph = lz4_pkg::PH_OFF0;
                end
                lz4_pkg::PH_LITEXT: begin
                    mdl_lit_left = sat_add(mdl_lit_left, 32'(b));
                    if (b != lz4_pkg::EXT_CONT) mdl_ph = lz4_pkg::PH_LIT;
                end
                lz4_pkg::PH_LIT: begin
                    mdl_emit(b);
                    r.out_byte = b; r.byte_valid = 1'b1;
                    mdl_lit_left--;
                    if (mdl_lit_left == 0) mdl_ph = lz4_pkg::PH_OFF0;
                end
                lz4_pkg::PH_OFF0: begin
                    mdl_offset = 16'(b); mdl_ph = lz4_pkg::PH_OFF1;
                end
                lz4_pkg::PH_OFF1: begin
                    mdl_offset[15:8] = b;
                    if (mdl_mnib == lz4_pkg::NIB_EXT) begin
                        mdl_mat_left = 32'd15; mdl_ph = lz4_pkg::PH_MEXT;
                    end else begin
                        mdl_mat_left = 32'(mdl_mnib) + 32'(lz4_pkg::MIN_MATCH);
                        r.status = mdl_start_match();
                    end
                end
                default: begin
                    mdl_mat_left = sat_add(mdl_mat_left, 32'(b));
                    if (b != lz4_pkg::EXT_CONT) begin
                        mdl_mat_left = sat_add(mdl_mat_left, 32'(lz4_pkg::MIN_MATCH));
                        r.status = mdl_start_match();
                    end
                end
            endcase
            mdl_consumed++;
            if (r.status != lz4_pkg::ST_OK) done = 1'b1;
            else if (mdl_frame ? (mdl_consumed >= mdl_bsize) : rq.eob) done = 1'b1;
        end
        if (done) mdl_restart();
        r.match_pending = (mdl_ph == lz4_pkg::PH_MATCH);
        r.block_done = done;
        return r;
    endfunction

    // driver side
    task automatic send(input req_t rq, input logic chk = 1'b0,
                        input lz4_pkg::result_t want = '0);
        lz4_pkg::result_t p;
        while (idle_send > 0 && $urandom_range(99) < idle_send) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        p = decode_step(rq);
        if (chk && p != want) report($sformatf("table row predicts %h, model %h", want, p));
        expected_q.push_back(p);
        s_tvalid <= 1'b1;
        s_tuser <= rq.pull; s_tdata <= rq.data; s_tlast <= rq.eob;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eob = 1'b0);
        req_t rq;
        rq.pull = 1'b0; rq.data = b; rq.eob = eob;
        send(rq);
        random_items++;
    endtask

    task automatic pull_all();
        req_t rq;
        rq = '{pull: 1'b1, data: 8'($urandom), eob: 1'($urandom)};
        while (mdl_ph == lz4_pkg::PH_MATCH) begin
            send(rq);
            random_items++;
            rq.data = 8'($urandom);
        end
    endtask

    task automatic drain_and_config(input logic mode);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we <= 1'b1; cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mdl_frame = mode;
        mdl_restart();
    endtask

    // one raw or frame-body sequence, mostly well formed
    task automatic random_sequence(input logic last_eob);
        int lits, mext;
        logic [15:0] off;
        logic [7:0] tok;
        lits = ($urandom_range(9) == 0) ? 15 + $urandom_range(300) : $urandom_range(14);
        tok[7:4] = lits >= 15 ? 4'hF : 4'(lits);
        tok[3:0] = ($urandom_range(5) == 0) ? 4'hF : 4'($urandom_range(14));
        send_byte(tok);
        if (lits >= 15) begin
            lits -= 15;
            while (lits >= 255) begin send_byte(8'hFF); lits -= 255; end
            send_byte(8'(lits));
        end
        while (mdl_ph == lz4_pkg::PH_LIT) send_byte(8'($urandom));
        if ($urandom_range(15) == 0) off = 16'($urandom);
        else if (mdl_produced == 0) off = 16'd1;
        else off = 16'($urandom_range(1, mdl_produced > 65535 ? 65535 : int'(mdl_produced)));
        send_byte(off[7:0]);
        send_byte(off[15:8], last_eob && tok[3:0] != lz4_pkg::NIB_EXT);
        if (mdl_ph == lz4_pkg::PH_MEXT) begin
            mext = $urandom_range(3) == 0 ? 255 : $urandom_range(40);
            send_byte(8'(mext));
            if (mext == 255) send_byte(8'($urandom_range(20)), last_eob);
        end
        if ($urandom_range(7) == 0) send_byte(8'($urandom)); // rejected while a match is pending
        pull_all();
    endtask

    task automatic random_frame();
        logic [7:0] flg;
        int nseq, bs;
        send_byte(lz4_pkg::MAGIC0);
        send_byte($urandom_range(19) == 0 ? 8'($urandom) : lz4_pkg::MAGIC1);
        if (mdl_ph != lz4_pkg::PH_MAGIC) return;
        send_byte(lz4_pkg::MAGIC2);
        send_byte(lz4_pkg::MAGIC3);
        flg = 8'($urandom);
        send_byte(flg);
        repeat (flg[3] ? 10 : 2) send_byte(8'($urandom));
        bs = $urandom_range(4) == 0 ? $urandom_range(3) : $urandom_range(10, 80);
        for (int i = 0; i < 4; i++) send_byte(8'(bs >> (8 * i)));
        nseq = 0;
        while (mdl_ph != lz4_pkg::PH_MAGIC && nseq < 40) begin
            random_sequence(1'b0);
            nseq++;
        end
    endtask

    row_t table_rows[$];

    function automatic row_t mk(input logic pull, input logic [7:0] d, input logic eob,
                                input logic chk = 1'b0,
                                input lz4_pkg::result_t want = '0);
        row_t r;
        r.rq = '{pull: pull, data: d, eob: eob};
        r.chk = chk; r.want = want;
        return r;
    endfunction

    initial begin
        lz4_pkg::result_t w_none, w_mag;
        w_none = '{out_byte: 8'h00, byte_valid: 1'b0, status: lz4_pkg::ST_NONE,
                   match_pending: 1'b0, block_done: 1'b0};
        w_mag  = '{out_byte: 8'h00, byte_valid: 1'b0, status: lz4_pkg::ST_BAD_MAG,
                   match_pending: 1'b0, block_done: 1'b1};
        for (int i = 0; i < 65536; i++) mdl_hist[i] = 8'h00;
        mdl_frame = 1'b0;
        mdl_restart();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // raw mode: pull with nothing pending, then literals ff/00 and a match
        table_rows.push_back(mk(1, 8'hFF, 1, 1, w_none));
        table_rows.push_back(mk(0, 8'h21, 0));  // 2 literals, match 5
        table_rows.push_back(mk(0, 8'hFF, 0));
        table_rows.push_back(mk(0, 8'h00, 0));
        table_rows.push_back(mk(0, 8'h01, 0));
        table_rows.push_back(mk(0, 8'h00, 0));
        table_rows.push_back(mk(0, 8'hAA, 1));  // busy, eob ignored
        for (int i = 0; i < 5; i++) table_rows.push_back(mk(1, 8'h00, 0));
        table_rows.push_back(mk(0, 8'h10, 0));  // 1 literal, offset 0: bad offset
        table_rows.push_back(mk(0, 8'h5A, 0));
        table_rows.push_back(mk(0, 8'h00, 0));
        table_rows.push_back(mk(0, 8'h00, 0));
        table_rows.push_back(mk(0, 8'hF0, 0));  // long literal then early eob
        table_rows.push_back(mk(0, 8'hFF, 0));
        table_rows.push_back(mk(0, 8'h03, 0));
        table_rows.push_back(mk(0, 8'h77, 1));
        table_rows.push_back(mk(0, 8'h10, 0));  // offset beyond produced
        table_rows.push_back(mk(0, 8'h33, 0));
        table_rows.push_back(mk(0, 8'h02, 0));
        table_rows.push_back(mk(0, 8'h00, 1));
        foreach (table_rows[i]) send(table_rows[i].rq, table_rows[i].chk, table_rows[i].want);

        // frame mode: bad magic, then zero block size
        drain_and_config(1'b1);
        send('{pull: 1'b0, data: 8'h05, eob: 1'b0}, 1'b1, w_mag);
        send_byte(lz4_pkg::MAGIC0); send_byte(lz4_pkg::MAGIC1);
        send_byte(lz4_pkg::MAGIC2); send_byte(lz4_pkg::MAGIC3);
        send_byte(8'h08);
        repeat (10) send_byte(8'hFF);
        repeat (4) send_byte(8'h00);
        random_items = 0;

        for (int ph = 0; ph < 4; ph++) begin
            idle_send = (ph == 1 || ph == 3) ? (ph == 3 ? 15 : 51) : 0;
            idle_recv = (ph == 2 || ph == 3) ? (ph == 3 ? 15 : 51) : 0;
            drain_and_config(1'b0);
            while (random_items < 200 * (2 * ph + 1)) begin
                if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'($urandom));
                else random_sequence($urandom_range(3) == 0);
            end
            drain_and_config(1'b1);
            while (random_items < 400 * (ph + 1) + 50) random_frame();
        end
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= (idle_recv == 0) ? 1'b1 : ($urandom_range(99) >= idle_recv);
    end

    always @(posedge aclk) begin
        lz4_pkg::result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = lz4_pkg::result_t'({m_tdata[7:0], m_tdata[8], m_tdata[11:9],
                                      m_tdata[12], m_tlast});
            if (expected_q.size() == 0) report("result with nothing expected");
            else begin
                want = expected_q.pop_front();
                if (got.out_byte != want.out_byte)
                    report($sformatf("out_byte %h want %h", got.out_byte, want.out_byte));
                if (got.byte_valid != want.byte_valid) report("byte_valid");
                if (got.status != want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
                if (got.match_pending != want.match_pending) report("match_pending");
                if (got.block_done != want.block_done) report("block_done");
            end
        end
    end

    initial begin
        #8000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
